// ----- hdl/ote_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ote_pkg;

  localparam int COLUMN_BITS_DEF = 12;
  localparam int TAB_STOP_DEF    = 8;
  localparam int SKIP_BITS_DEF   = 16;

  localparam int MAX_RESULTS = 53;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam int PRE_LEN   = 8;
  localparam int PRE_IDX_W = $clog2(PRE_LEN);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_Y     = 8'h59;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  // font selection words sent ahead of the first word after reset or after end of stream
  localparam logic [7:0] PREAMBLE [PRE_LEN] = '{
    8'h1B, 8'h2D, 8'h1B, 8'h49, 8'h7E, 8'h41, 8'h00, 8'h04
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRE,
    ST_DECIDE,
    ST_RAW_HELD,
    ST_UL_ESC,
    ST_UL_CODE,
    ST_BD_ESC,
    ST_BD_CODE,
    ST_HELD,
    ST_OVER_BS,
    ST_OVER_CH,
    ST_TAB,
    ST_FLUSH
  } ote_state_t;

  typedef struct packed {
    logic       start;
    logic       emit;
    logic       flush;
    logic [7:0] data;
  } ote_emit_req_t;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

endpackage

`default_nettype wire

// ----- hdl/ote_emit.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ote_emit (
  input  wire                   clk,
  input  wire                   rst_n,
  input  ote_pkg::ote_emit_req_t req,
  output logic                  ok,
  output logic                  out_valid,
  input  wire                   out_stall,
  output logic [7:0]            out_byte,
  output logic                  out_last_of_run
);

  import ote_pkg::*;

  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r;
  logic             pend_valid_r;
  logic [7:0]       pend_byte_r;
  logic [CNT_W-1:0] cnt_r;

  logic out_free;
  logic capped;
  logic push_word;
  logic push_last;

  assign out_free = !out_valid_r || !out_stall;
  assign capped   = (cnt_r == CNT_W'(MAX_RESULTS));
  // words past the cap are dropped, so the sequencer never waits on them
  assign ok       = (req.emit && capped) || !pend_valid_r || out_free;

  // one word is held back until we know whether it closes the run
  assign push_word = req.emit && !capped && pend_valid_r && out_free;
  assign push_last = req.flush && pend_valid_r && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      cnt_r        <= '0;
    end else begin
      if (push_word || push_last) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (req.emit && !capped && ok) begin
        pend_valid_r <= 1'b1;
      end else if (push_last) begin
        pend_valid_r <= 1'b0;
      end
      if (req.start) begin
        cnt_r <= '0;
      end else if (req.emit && !capped) begin
        if (ok) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_word || push_last) begin
      out_byte_r <= pend_byte_r;
      out_last_r <= push_last;
    end
    if (req.emit && !capped && ok) begin
      pend_byte_r <= req.data;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;

  a_flush_marks_last : assert property (@(posedge clk) disable iff (!rst_n)
    push_last |=> out_valid_r && out_last_r)
    else $error("closing word not marked last");

  a_cnt_capped : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_RESULTS))
    else $error("word count beyond cap");

endmodule

`default_nettype wire

// ----- hdl/ote_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ote_core #(
  parameter int COLUMN_BITS = ote_pkg::COLUMN_BITS_DEF,
  parameter int TAB_STOP    = ote_pkg::TAB_STOP_DEF,
  parameter int SKIP_BITS   = ote_pkg::SKIP_BITS_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  input  wire  [7:0]             in_byte,
  input  wire                    in_end_of_stream,
  output logic                   busy,
  output ote_pkg::ote_emit_req_t req,
  input  wire                    ok
);

  import ote_pkg::*;

  localparam int MOD_W    = $clog2(TAB_STOP);
  localparam int SPC_W    = $clog2(TAB_STOP + 1);
  localparam int WRAP_MOD = ((2 ** COLUMN_BITS) - 1) % TAB_STOP;

  ote_state_t state_r, state_nxt;

  logic [7:0]             byte_r, byte_nxt;
  logic                   eos_r, eos_nxt;
  logic [7:0]             held_r, held_nxt;
  logic [SKIP_BITS-1:0]   skip_r, skip_nxt;
  logic [COLUMN_BITS-1:0] col_r, col_nxt;
  logic [MOD_W-1:0]       mod_r, mod_nxt;
  logic                   ul_seen_r, ul_seen_nxt;
  logic                   ul_sent_r, ul_sent_nxt;
  logic                   bd_sent_r, bd_sent_nxt;
  logic                   ul_want_r, ul_want_nxt;
  logic                   bd_want_r, bd_want_nxt;
  logic                   esc_pend_r, esc_pend_nxt;
  logic [1:0]             phase_r, phase_nxt;
  logic                   pre_done_r, pre_done_nxt;
  logic [PRE_IDX_W-1:0]   pre_idx_r, pre_idx_nxt;
  logic [7:0]             next_r, next_nxt;
  logic                   over_r, over_nxt;
  logic [SPC_W-1:0]       spaces_r, spaces_nxt;
  logic                   rst_after_r, rst_after_nxt;

  logic                   in_acc;
  logic                   is_bs;
  logic                   dec_raw;
  logic                   dec_fin;
  logic                   ul_want_eff;
  logic                   held_print;
  logic [COLUMN_BITS-1:0] col_inc, col_dec;
  logic [MOD_W-1:0]       mod_inc, mod_dec;
  logic [SKIP_BITS:0]     skip_sum1, skip_sum2;
  logic [SKIP_BITS-1:0]   skip_add1, skip_add2;

  assign busy   = (state_r != ST_IDLE);
  assign in_acc = in_valid && (state_r == ST_IDLE);
  assign is_bs  = (byte_r == CH_BS);

  // branch taken on the held byte and the new byte
  assign dec_raw = !eos_r && (phase_r == 2'd1) && (held_r != CH_UNDER)
                   && (byte_r != held_r) && is_bs;
  assign dec_fin = eos_r
    || ((phase_r == 2'd1) && (held_r != CH_UNDER) && (byte_r != held_r) && !is_bs)
    || (phase_r[1] && !is_bs)
    || ((phase_r == 2'd0) && esc_pend_r && (byte_r != CH_X) && (byte_r != CH_Y))
    || ((phase_r == 2'd0) && !esc_pend_r && !is_bs);

  assign ul_want_eff = ul_want_r || (ul_seen_r && is_letter(held_r));
  assign held_print  = (held_r != CH_NUL) && (skip_r == '0);

  // column and its remainder by the tab stop, both wrapping with the column
  assign col_inc = col_r + COLUMN_BITS'(1);
  assign col_dec = col_r - COLUMN_BITS'(1);
  assign mod_inc = ((col_r == '1) || (mod_r == MOD_W'(TAB_STOP - 1))) ? '0
                   : mod_r + MOD_W'(1);
  assign mod_dec = (col_r == '0) ? MOD_W'(WRAP_MOD)
                   : (mod_r == '0) ? MOD_W'(TAB_STOP - 1)
                   : mod_r - MOD_W'(1);

  assign skip_sum1 = {1'b0, skip_r} + (SKIP_BITS+1)'(1);
  assign skip_sum2 = {1'b0, skip_r} + (SKIP_BITS+1)'(2);
  assign skip_add1 = skip_sum1[SKIP_BITS] ? '1 : skip_sum1[SKIP_BITS-1:0];
  assign skip_add2 = skip_sum2[SKIP_BITS] ? '1 : skip_sum2[SKIP_BITS-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = pre_done_r ? ST_DECIDE : ST_PRE;
        end
      end
      ST_PRE: begin
        if (ok && (pre_idx_r == PRE_IDX_W'(PRE_LEN - 1))) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_nxt = dec_raw ? ST_RAW_HELD : dec_fin ? ST_UL_ESC : ST_FLUSH;
      end
      ST_RAW_HELD: begin
        if ((held_r == CH_NUL) || ok) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_UL_ESC: begin
        if (ul_want_eff == ul_sent_r) begin
          state_nxt = ST_BD_ESC;
        end else if (ok) begin
          state_nxt = ST_UL_CODE;
        end
      end
      ST_UL_CODE: begin
        if (ok) begin
          state_nxt = ST_BD_ESC;
        end
      end
      ST_BD_ESC: begin
        if (bd_want_r == bd_sent_r) begin
          state_nxt = ST_HELD;
        end else if (ok) begin
          state_nxt = ST_BD_CODE;
        end
      end
      ST_BD_CODE: begin
        if (ok) begin
          state_nxt = ST_HELD;
        end
      end
      ST_HELD: begin
        if (!held_print || ok) begin
          state_nxt = over_r ? ST_OVER_BS : (spaces_r != '0) ? ST_TAB : ST_FLUSH;
        end
      end
      ST_OVER_BS: begin
        if (ok) begin
          state_nxt = ST_OVER_CH;
        end
      end
      ST_OVER_CH: begin
        if (ok) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_TAB: begin
        state_nxt = ST_UL_ESC;
      end
      ST_FLUSH: begin
        if (ok) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath and emit requests
  always_comb begin
    byte_nxt      = byte_r;
    eos_nxt       = eos_r;
    held_nxt      = held_r;
    skip_nxt      = skip_r;
    col_nxt       = col_r;
    mod_nxt       = mod_r;
    ul_seen_nxt   = ul_seen_r;
    ul_sent_nxt   = ul_sent_r;
    bd_sent_nxt   = bd_sent_r;
    ul_want_nxt   = ul_want_r;
    bd_want_nxt   = bd_want_r;
    esc_pend_nxt  = esc_pend_r;
    phase_nxt     = phase_r;
    pre_done_nxt  = pre_done_r;
    pre_idx_nxt   = pre_idx_r;
    next_nxt      = next_r;
    over_nxt      = over_r;
    spaces_nxt    = spaces_r;
    rst_after_nxt = rst_after_r;
    req           = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          byte_nxt  = in_byte;
          eos_nxt   = in_end_of_stream;
          req.start = 1'b1;
        end
      end
      ST_PRE: begin
        req.emit = 1'b1;
        req.data = PREAMBLE[pre_idx_r];
        if (ok) begin
          pre_idx_nxt = pre_idx_r + PRE_IDX_W'(1);
          if (pre_idx_r == PRE_IDX_W'(PRE_LEN - 1)) begin
            pre_done_nxt = 1'b1;
          end
        end
      end
      ST_DECIDE: begin
        over_nxt   = 1'b0;
        spaces_nxt = '0;
        next_nxt   = byte_r;
        priority if (eos_r) begin
          esc_pend_nxt  = 1'b0;
          next_nxt      = CH_NUL;
          rst_after_nxt = 1'b1;
        end else if (phase_r == 2'd1) begin
          phase_nxt = 2'd0;
          priority if (held_r == CH_UNDER) begin
            ul_want_nxt = 1'b1;
            held_nxt    = byte_r;
          end else if (byte_r == held_r) begin
            bd_want_nxt = 1'b1;
          end else if (is_bs) begin
            phase_nxt = 2'd2;
          end else begin
            over_nxt = 1'b1;
          end
        end else if (phase_r[1]) begin
          if (is_bs) begin
            skip_nxt = skip_add1;
            col_nxt  = col_dec;
            mod_nxt  = mod_dec;
          end else begin
            phase_nxt = 2'd0;
            held_nxt  = CH_NUL;
            skip_nxt  = skip_add2;
          end
        end else if (esc_pend_r) begin
          priority if (byte_r == CH_X) begin
            ul_seen_nxt = 1'b1;
            held_nxt    = CH_NUL;
          end else if (byte_r == CH_Y) begin
            ul_seen_nxt = 1'b0;
            held_nxt    = CH_NUL;
          end else begin
            esc_pend_nxt = 1'b0;
          end
        end else if (is_bs) begin
          phase_nxt = 2'd1;
        end else begin
          priority if (byte_r == CH_NL) begin
            col_nxt = '0;
            mod_nxt = '0;
          end else if (byte_r == CH_TAB) begin
            spaces_nxt = SPC_W'(TAB_STOP) - SPC_W'(mod_r);
            next_nxt   = CH_NUL;
          end else if (byte_r == CH_ESC) begin
            esc_pend_nxt = 1'b1;
          end else begin
            col_nxt = col_inc;
            mod_nxt = mod_inc;
          end
        end
      end
      ST_RAW_HELD: begin
        // lone backspace followed by another one: print the held byte as is
        req.emit = (held_r != CH_NUL);
        req.data = held_r;
        if (!req.emit || ok) begin
          held_nxt = CH_NUL;
        end
      end
      ST_UL_ESC: begin
        ul_want_nxt = ul_want_eff;
        req.emit    = (ul_want_eff != ul_sent_r);
        req.data    = CH_ESC;
      end
      ST_UL_CODE: begin
        req.emit = 1'b1;
        req.data = ul_want_r ? CH_X : CH_Y;
        if (ok) begin
          ul_sent_nxt = ul_want_r;
        end
      end
      ST_BD_ESC: begin
        req.emit = (bd_want_r != bd_sent_r);
        req.data = CH_ESC;
      end
      ST_BD_CODE: begin
        req.emit = 1'b1;
        req.data = bd_want_r ? CH_BANG : CH_QUOTE;
        if (ok) begin
          bd_sent_nxt = bd_want_r;
        end
      end
      ST_HELD: begin
        req.emit = held_print;
        req.data = held_r;
        if (!held_print || ok) begin
          if ((held_r != CH_NUL) && (skip_r != '0)) begin
            skip_nxt = skip_r - SKIP_BITS'(1);
          end
          held_nxt    = next_r;
          ul_want_nxt = 1'b0;
          bd_want_nxt = 1'b0;
        end
      end
      ST_OVER_BS: begin
        req.emit = 1'b1;
        req.data = CH_BS;
      end
      ST_OVER_CH: begin
        req.emit = 1'b1;
        req.data = next_r;
        if (ok) begin
          held_nxt = CH_NUL;
          over_nxt = 1'b0;
        end
      end
      ST_TAB: begin
        col_nxt    = col_inc;
        mod_nxt    = mod_inc;
        spaces_nxt = spaces_r - SPC_W'(1);
        next_nxt   = CH_SPACE;
      end
      ST_FLUSH: begin
        req.flush = 1'b1;
        if (ok && rst_after_r) begin
          held_nxt      = CH_NUL;
          skip_nxt      = '0;
          col_nxt       = '0;
          mod_nxt       = '0;
          ul_seen_nxt   = 1'b0;
          ul_sent_nxt   = 1'b0;
          bd_sent_nxt   = 1'b0;
          ul_want_nxt   = 1'b0;
          bd_want_nxt   = 1'b0;
          esc_pend_nxt  = 1'b0;
          phase_nxt     = 2'd0;
          pre_done_nxt  = 1'b0;
          rst_after_nxt = 1'b0;
        end
      end
      default: begin
        req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      held_r      <= CH_NUL;
      skip_r      <= '0;
      col_r       <= '0;
      mod_r       <= '0;
      ul_seen_r   <= 1'b0;
      ul_sent_r   <= 1'b0;
      bd_sent_r   <= 1'b0;
      ul_want_r   <= 1'b0;
      bd_want_r   <= 1'b0;
      esc_pend_r  <= 1'b0;
      phase_r     <= 2'd0;
      pre_done_r  <= 1'b0;
      pre_idx_r   <= '0;
      over_r      <= 1'b0;
      spaces_r    <= '0;
      rst_after_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      skip_r      <= skip_nxt;
      col_r       <= col_nxt;
      mod_r       <= mod_nxt;
      ul_seen_r   <= ul_seen_nxt;
      ul_sent_r   <= ul_sent_nxt;
      bd_sent_r   <= bd_sent_nxt;
      ul_want_r   <= ul_want_nxt;
      bd_want_r   <= bd_want_nxt;
      esc_pend_r  <= esc_pend_nxt;
      phase_r     <= phase_nxt;
      pre_done_r  <= pre_done_nxt;
      pre_idx_r   <= pre_idx_nxt;
      over_r      <= over_nxt;
      spaces_r    <= spaces_nxt;
      rst_after_r <= rst_after_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    eos_r  <= eos_nxt;
    next_r <= next_nxt;
  end

  a_phase_code : assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != 2'd3)
    else $error("backspace phase out of range");

  a_preamble_first : assert property (@(posedge clk) disable iff (!rst_n)
    !pre_done_r |-> (state_r == ST_IDLE) || (state_r == ST_PRE))
    else $error("item processed before preamble");

  a_tab_drained : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (spaces_r == '0) && !over_r)
    else $error("item left with tab or overstrike work");

endmodule

`default_nettype wire

// ----- hdl/overstrike_to_escape_filter.sv -----
// Overstrike to escape filter: typesetter byte stream in, printer bytes out.
// Input channel: in_valid / in_stall with in_byte and in_end_of_stream; one
// word per accepted byte. Result channel: out_valid / out_stall with out_byte
// and out_last_of_run, which marks the final word caused by an input word.
// An input word may cause no result at all (held back for lookahead).
// Flow: a sequencer walks one input word through decode and the shared
// finish steps (underline escape, bold escape, held character, overstrike),
// emitting at most one output word per cycle while the receiver does not
// stall. A new input word is taken only once the last one is done; each
// escape pair, overstrike and tab space adds steps, as does the font preamble
// for the first word after reset or after end of stream.
// in_stall is high while a word is in progress.
// Output: one word is held back to mark the last, and it moves out when the
// next word of its run is produced or when the run closes.
// Receiver stall: the output register and the hold stage fill, then the
// sequencer waits in place; nothing is lost. More than 53 words for one input
// word are dropped. Reset (synchronous, rst_n low) clears all control state; the
// preamble is then sent again before the next output.
`timescale 1ns / 1ps
`default_nettype none

module overstrike_to_escape_filter #(
  parameter int COLUMN_BITS = ote_pkg::COLUMN_BITS_DEF,
  parameter int TAB_STOP    = ote_pkg::TAB_STOP_DEF,
  parameter int SKIP_BITS   = ote_pkg::SKIP_BITS_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire  [7:0] in_byte,
  input  wire        in_end_of_stream,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [7:0] out_byte,
  output logic       out_last_of_run
);

  import ote_pkg::*;

  ote_emit_req_t req;
  logic          ok;
  logic          busy;

  ote_core #(
    .COLUMN_BITS (COLUMN_BITS),
    .TAB_STOP    (TAB_STOP),
    .SKIP_BITS   (SKIP_BITS)
  ) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_byte          (in_byte),
    .in_end_of_stream (in_end_of_stream),
    .busy             (busy),
    .req              (req),
    .ok               (ok)
  );

  ote_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .req             (req),
    .ok              (ok),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

  assign in_stall = busy;

  a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("block not busy after taking a word");

endmodule

`default_nettype wire

// ----- tb/escape_stream_check_pkg.sv -----
`timescale 1ns / 1ps

package escape_stream_check_pkg;
  import ote_pkg::*;

  localparam int COL_W  = COLUMN_BITS_DEF;
  localparam int SKIP_W = SKIP_BITS_DEF;
  localparam int TAB_W  = TAB_STOP_DEF;

  // font select: ESC '-' ESC 'I' '~' 'A' NUL EOT
  localparam logic [7:0] FONT_PREFIX [8] = '{
    8'h1B, 8'h2D, 8'h1B, 8'h49, 8'h7E, 8'h41, 8'h00, 8'h04
  };

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } printer_word_t;

  class escape_stream_scoreboard;
    printer_word_t expected_words[$];
    printer_word_t step_words[$];
    int errors;

    logic [7:0]        held;
    logic [SKIP_W-1:0] skip;
    logic [COL_W-1:0]  col;
    logic [1:0]        bs_phase;
    bit ul_seen, ul_sent, bd_sent, ul_want, bd_want, esc_pend, font_sent;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      held      = CH_NUL;
      skip      = '0;
      col       = '0;
      bs_phase  = 2'd0;
      ul_seen   = 1'b0;
      ul_sent   = 1'b0;
      bd_sent   = 1'b0;
      ul_want   = 1'b0;
      bd_want   = 1'b0;
      esc_pend  = 1'b0;
      font_sent = 1'b0;
    endfunction

    function void put(logic [7:0] b);
      printer_word_t w;
      w.data = b;
      w.last = 1'b0;
      // words past the per-step cap are dropped
      if (step_words.size() < MAX_RESULTS) step_words.push_back(w);
    endfunction

    function bit letter(logic [7:0] c);
      return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function void add_skip(int unsigned k);
      longint unsigned s;
      longint unsigned lim;
      lim = (64'd1 << SKIP_W) - 1;
      s = skip;
      s = s + k;
      skip = (s > lim) ? lim[SKIP_W-1:0] : s[SKIP_W-1:0];
    endfunction

    // escape changes, print the held character, take the next one
    function void settle(logic [7:0] nxt, bit over);
      if (ul_seen && letter(held)) ul_want = 1'b1;
      if (ul_want && !ul_sent) begin
        put(CH_ESC); put(CH_X); ul_sent = 1'b1;
      end else if (!ul_want && ul_sent) begin
        put(CH_ESC); put(CH_Y); ul_sent = 1'b0;
      end
      if (bd_want && !bd_sent) begin
        put(CH_ESC); put(CH_BANG); bd_sent = 1'b1;
      end else if (!bd_want && bd_sent) begin
        put(CH_ESC); put(CH_QUOTE); bd_sent = 1'b0;
      end
      if (held != CH_NUL) begin
        if (skip != 0) skip = skip - 1'b1;
        else put(held);
      end
      held = nxt;
      if (over) begin
        put(CH_BS);
        put(nxt);
        held = CH_NUL;
      end
      ul_want = 1'b0;
      bd_want = 1'b0;
    endfunction

    function void take_input_word(logic [7:0] b, logic eos);
      int unsigned spaces;
      logic [7:0] nxt;
      printer_word_t w;
      step_words.delete();
      if (!font_sent) begin
        foreach (FONT_PREFIX[i]) put(FONT_PREFIX[i]);
        font_sent = 1'b1;
      end
      if (eos) begin
        esc_pend = 1'b0;
        settle(CH_NUL, 1'b0);
        clear();
      end else if (bs_phase == 2'd1) begin
        bs_phase = 2'd0;
        if (held == CH_UNDER) begin
          ul_want = 1'b1;
          held = b;
        end else if (b == held) begin
          bd_want = 1'b1;
        end else if (b == CH_BS) begin
          if (held != CH_NUL) put(held);
          held = CH_NUL;
          bs_phase = 2'd2;
        end else begin
          settle(b, 1'b1);
        end
      end else if (bs_phase >= 2'd2) begin
        if (b == CH_BS) begin
          add_skip(1);
          col = col - 1'b1;
        end else begin
          bs_phase = 2'd0;
          held = CH_NUL;
          add_skip(2);
          settle(b, 1'b0);
        end
      end else if (esc_pend) begin
        if (b == CH_X) begin
          ul_seen = 1'b1;
          held = CH_NUL;
        end else if (b == CH_Y) begin
          ul_seen = 1'b0;
          held = CH_NUL;
        end else begin
          esc_pend = 1'b0;
          settle(b, 1'b0);
        end
      end else if (b == CH_BS) begin
        bs_phase = 2'd1;
      end else begin
        spaces = 0;
        nxt = b;
        if (b == CH_NL) begin
          col = '0;
        end else if (b == CH_TAB) begin
          spaces = TAB_W - (int'(col) % TAB_W);
          nxt = CH_NUL;
        end else if (b == CH_ESC) begin
          esc_pend = 1'b1;
        end else begin
          col = col + 1'b1;
        end
        settle(nxt, 1'b0);
        while (spaces != 0) begin
          col = col + 1'b1;
          settle(CH_SPACE, 1'b0);
          spaces--;
        end
      end
      if (step_words.size() > 0) begin
        w = step_words.pop_back();
        w.last = 1'b1;
        step_words.push_back(w);
      end
      foreach (step_words[i]) expected_words.push_back(step_words[i]);
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void check_printer_word(logic [7:0] b, logic last);
      printer_word_t w;
      if (expected_words.size() == 0) begin
        note_error($sformatf("unexpected word %02h last %0b", b, last));
        return;
      end
      w = expected_words.pop_front();
      if (w.data !== b || w.last !== last)
        note_error($sformatf("word mismatch: expected %02h last %0b, got %02h last %0b",
                             w.data, w.last, b, last));
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

endpackage

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import ote_pkg::*;
  import escape_stream_check_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_WORDS = 450;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic       in_end_of_stream = 1'b0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last_of_run;

  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  bit hold_req = 1'b0;
  int words_sent = 0;
  int quiet_cycles = 0;

  escape_stream_scoreboard stream_check = new();

  initial begin
    forever #5 clk = ~clk;
  end

  overstrike_to_escape_filter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_end_of_stream (in_end_of_stream),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_last_of_run  (out_last_of_run)
  );

  // no word moving on either side for too long means the block is stuck
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : printer_side
    int gap;
    wait (rst_n === 1'b1);
    forever begin
      gap = recv_idle ? $urandom_range(0, 6) : 0;
      if (hold_req) begin
        hold_req = 1'b0;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      stream_check.check_printer_word(out_byte, out_last_of_run);
    end
  end

  task automatic send_word(input logic [7:0] b, input logic eos);
    int gap;
    gap = send_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_byte <= b;
    in_end_of_stream <= eos;
    do @(posedge clk); while (in_stall !== 1'b0);
    stream_check.take_input_word(b, eos);
    words_sent++;
  endtask

  task automatic wait_for_printer();
    @(negedge clk);
    in_valid <= 1'b0;
    while (stream_check.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_letter();
    logic [7:0] c;
    c = $urandom_range(0, 1) ? 8'($urandom_range(8'h41, 8'h5A))
                             : 8'($urandom_range(8'h61, 8'h7A));
    return c;
  endfunction

  function automatic logic [7:0] pick_plain();
    logic [7:0] c;
    c = ($urandom_range(0, 2) != 0) ? pick_letter() : 8'($urandom_range(8'h20, 8'h7E));
    return c;
  endfunction

  task automatic send_fragment();
    int kind;
    int n;
    logic [7:0] c;
    kind = $urandom_range(0, 19);
    case (kind)
      0, 1, 2, 3: begin
        n = $urandom_range(1, 8);
        repeat (n) send_word(pick_plain(), 1'b0);
      end
      4, 5: begin
        send_word(CH_UNDER, 1'b0);
        send_word(CH_BS, 1'b0);
        send_word(pick_plain(), 1'b0);
      end
      6, 7: begin
        c = pick_plain();
        send_word(c, 1'b0);
        send_word(CH_BS, 1'b0);
        send_word(c, 1'b0);
      end
      8: begin
        send_word(pick_plain(), 1'b0);
        send_word(CH_BS, 1'b0);
        send_word(pick_plain(), 1'b0);
      end
      9: begin
        send_word(pick_plain(), 1'b0);
        send_word(CH_BS, 1'b0);
        send_word(CH_BS, 1'b0);
        n = $urandom_range(0, 5);
        repeat (n) send_word(CH_BS, 1'b0);
        send_word(($urandom_range(0, 3) == 0) ? 8'($urandom) : pick_plain(), 1'b0);
      end
      10: begin
        send_word(CH_ESC, 1'b0);
        send_word(CH_X, 1'b0);
      end
      11: begin
        send_word(CH_ESC, 1'b0);
        send_word(CH_Y, 1'b0);
      end
      12: begin
        send_word(CH_ESC, 1'b0);
        send_word(pick_plain(), 1'b0);
      end
      13: send_word(CH_TAB, 1'b0);
      14: send_word(CH_NL, 1'b0);
      15: send_word(8'($urandom), 1'b1);
      16, 17: begin
        n = $urandom_range(1, 3);
        repeat (n) send_word(8'($urandom), 1'b0);
      end
      default: begin
        // underlined region followed by its closing escape
        send_word(CH_ESC, 1'b0);
        send_word(CH_X, 1'b0);
        n = $urandom_range(1, 6);
        repeat (n) send_word(pick_plain(), 1'b0);
        send_word(CH_ESC, 1'b0);
        send_word(CH_Y, 1'b0);
      end
    endcase
  endtask

  initial begin : stimulus
    int next_pause;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // end of stream on the very first word still gets the font preamble
    send_word(8'hFF, 1'b1);
    send_word("z", 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(CH_NUL, 1'b0);
    send_word(CH_UNDER, 1'b0);
    send_word(CH_BS, 1'b0);
    send_word("a", 1'b0);
    send_word("b", 1'b0);
    send_word(CH_BS, 1'b0);
    send_word("b", 1'b0);
    send_word("c", 1'b0);
    send_word(CH_BS, 1'b0);
    send_word("d", 1'b0);
    send_word("e", 1'b0);
    send_word(CH_BS, 1'b0);
    send_word(CH_BS, 1'b0);
    send_word(CH_BS, 1'b0);
    send_word(CH_TAB, 1'b0);
    send_word(CH_ESC, 1'b0);
    send_word(CH_X, 1'b0);
    send_word("g", 1'b0);
    send_word(CH_ESC, 1'b0);
    send_word(CH_Y, 1'b0);
    send_word(CH_TAB, 1'b0);
    send_word(CH_NL, 1'b0);
    send_word("i", 1'b0);
    send_word(CH_BS, 1'b0);
    send_word(8'h00, 1'b1);
    wait_for_printer();

    // printer side holds off a long while, the input keeps offering words
    hold_req = 1'b1;
    send_idle = 1'b0;
    next_pause = words_sent + 150;
    while (words_sent < RANDOM_WORDS - 16) begin
      if ($urandom_range(0, 11) == 0) send_idle = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 11) == 0) recv_idle = ($urandom_range(0, 3) != 0);
      send_fragment();
      if (words_sent >= next_pause) begin
        wait_for_printer();
        next_pause = words_sent + 150;
      end
    end
    wait_for_printer();

    // backspace run from the start of a line wraps the column downwards
    send_idle = 1'b0;
    recv_idle = 1'b0;
    send_word(CH_NL, 1'b0);
    send_word("a", 1'b0);
    send_word(CH_BS, 1'b0);
    send_word(CH_BS, 1'b0);
    repeat (6) send_word(CH_BS, 1'b0);
    send_word("b", 1'b0);
    send_word("c", 1'b0);
    send_word(CH_TAB, 1'b0);
    send_word(8'h00, 1'b1);
    wait_for_printer();
    repeat (20) @(posedge clk);

    if (stream_check.errors == 0 && stream_check.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
